/* hdl/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared constants for the sphere-sphere contact pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

    localparam int SSC_COORD_BITS       = 24;
    localparam int SSC_NORMAL_FRAC_BITS = 14;
    localparam int SSC_NORMAL_WIDTH     = 16;

endpackage

`default_nettype wire

/* hdl/sphere_sphere_contact_top.sv */
// ----------------------------------------------------------------------------
// sphere_sphere_contact_top
// Sphere pair contact test: hit flag, unit normal A to B, penetration depth.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_ready carry one sphere pair word (two centers in
// signed Q15.8, two radii in unsigned Q15.8). Output channel: o_valid /
// i_ready carry one result word (hit, Q1.14 normal, Q16.8 depth, coincident).
// Every pair yields exactly one result, in order.
// The pipeline has three stages for difference, squares and sum of squares, one
// stage per root bit of the square root (COORD_BITS + 2), one compare stage, one
// stage per quotient bit of the three normal dividers (NORMAL_FRAC_BITS + 1) and
// an output register. One pair is taken every cycle while the pipeline is not
// stalled by the receiver.
// Each stage holds only while it is full and the stage after it holds, so a
// stalled receiver backs the pipeline up stage by stage and empty slots are
// filled in; nothing is dropped or repeated.
// Synchronous active-low reset clears all stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_sphere_contact_top
    import ssc_pkg::*;
#(
    parameter int COORD_BITS       = SSC_COORD_BITS,
    parameter int NORMAL_FRAC_BITS = SSC_NORMAL_FRAC_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [COORD_BITS-1:0] i_center_a_x,
    input  wire logic signed [COORD_BITS-1:0] i_center_a_y,
    input  wire logic signed [COORD_BITS-1:0] i_center_a_z,
    input  wire logic        [COORD_BITS-2:0] i_radius_a,
    input  wire logic signed [COORD_BITS-1:0] i_center_b_x,
    input  wire logic signed [COORD_BITS-1:0] i_center_b_y,
    input  wire logic signed [COORD_BITS-1:0] i_center_b_z,
    input  wire logic        [COORD_BITS-2:0] i_radius_b,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic                              o_hit,
    output logic signed [SSC_NORMAL_WIDTH-1:0] o_normal_x,
    output logic signed [SSC_NORMAL_WIDTH-1:0] o_normal_y,
    output logic signed [SSC_NORMAL_WIDTH-1:0] o_normal_z,
    output logic        [COORD_BITS-1:0]      o_depth,
    output logic                              o_coincident
);

    localparam int W  = COORD_BITS;
    localparam int F  = NORMAL_FRAC_BITS;
    localparam int OW = SSC_NORMAL_WIDTH;
    localparam int DW = W + 2;
    localparam int SW = 2 * DW;
    localparam int NQ = F + 1;
    localparam int NW = DW + F;
    localparam int CS = 3 + DW;
    localparam int D0 = CS + 1;
    localparam int OS = D0 + NQ;
    localparam int L  = OS + 1;

    // ---------------- valid / ready chain ----------------
    logic [L-1:0] r_vld;
    logic [L:0]   rdy;
    logic [L-1:0] vin;

    assign rdy[L] = i_ready;
    assign vin    = {r_vld[L-2:0], i_valid};

    genvar k;
    generate
        for (k = 0; k < L; k++) begin : g_ctl
            assign rdy[k] = !r_vld[k] || rdy[k+1];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (rdy[k]) begin
                    r_vld[k] <= vin[k];
                end
            end
        end
    endgenerate

    assign o_ready = rdy[0];
    assign o_valid = r_vld[OS];

    // ---------------- stage 0: differences ----------------
    logic signed [W-1:0] ca [3];
    logic signed [W-1:0] cb [3];
    logic        [W:0]   r_m0  [3];
    logic        [2:0]   r_s0;
    logic        [W-1:0] r_sr0;

    assign ca[0] = i_center_a_x;
    assign ca[1] = i_center_a_y;
    assign ca[2] = i_center_a_z;
    assign cb[0] = i_center_b_x;
    assign cb[1] = i_center_b_y;
    assign cb[2] = i_center_b_z;

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_diff
            logic signed [W:0] d;
            assign d = $signed({cb[c][W-1], cb[c]}) - $signed({ca[c][W-1], ca[c]});
            always_ff @(posedge i_clk) begin
                if (rdy[0]) begin
                    r_m0[c] <= d[W] ? (~d + 1'b1) : d;
                    r_s0[c] <= d[W];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_sr0 <= {1'b0, i_radius_a} + {1'b0, i_radius_b};
        end
    end

    // ---------------- stage 1: squares ----------------
    logic [2*W+1:0] r_sq [3];
    logic [W:0]     r_m1 [3];
    logic [2:0]     r_s1;
    logic [W-1:0]   r_sr1;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_m0[i] * r_m0[i];
                r_m1[i] <= r_m0[i];
            end
            r_s1  <= r_s0;
            r_sr1 <= r_sr0;
        end
    end

    // ---------------- stage 2: sum of squares ----------------
    logic [SW-1:0] r_rad;
    logic [W:0]    r_m2 [3];
    logic [2:0]    r_s2;
    logic [W-1:0]  r_sr2;

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_rad <= {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};
            for (int i = 0; i < 3; i++) begin
                r_m2[i] <= r_m1[i];
            end
            r_s2  <= r_s1;
            r_sr2 <= r_sr1;
        end
    end

    // ---------------- square root, one root bit per stage ----------------
    logic [DW-1:0] r_qr  [DW];
    logic [DW:0]   r_qm  [DW];
    logic [SW-1:0] r_qx  [DW];
    logic [W:0]    r_qmx [DW];
    logic [W:0]    r_qmy [DW];
    logic [W:0]    r_qmz [DW];
    logic [2:0]    r_qsg [DW];
    logic [W-1:0]  r_qsr [DW];

    genvar j;
    generate
        for (j = 0; j < DW; j++) begin : g_sqrt
            logic [DW-1:0] root_in;
            logic [DW:0]   rem_in;
            logic [SW-1:0] rad_in;
            logic [W:0]    mx_in;
            logic [W:0]    my_in;
            logic [W:0]    mz_in;
            logic [2:0]    sg_in;
            logic [W-1:0]  sr_in;
            logic [DW+2:0] t;
            logic [DW+2:0] trial;
            logic [DW+2:0] diff;
            logic          ge;

            if (j == 0) begin : g_first
                assign root_in = '0;
                assign rem_in  = '0;
                assign rad_in  = r_rad;
                assign mx_in   = r_m2[0];
                assign my_in   = r_m2[1];
                assign mz_in   = r_m2[2];
                assign sg_in   = r_s2;
                assign sr_in   = r_sr2;
            end else begin : g_next
                assign root_in = r_qr[j-1];
                assign rem_in  = r_qm[j-1];
                assign rad_in  = r_qx[j-1];
                assign mx_in   = r_qmx[j-1];
                assign my_in   = r_qmy[j-1];
                assign mz_in   = r_qmz[j-1];
                assign sg_in   = r_qsg[j-1];
                assign sr_in   = r_qsr[j-1];
            end

            always_comb begin
                t     = {rem_in, rad_in[SW-1:SW-2]};
                trial = {1'b0, root_in, 2'b01};
                diff  = t - trial;
                ge    = (t >= trial);
            end

            always_ff @(posedge i_clk) begin
                if (rdy[3+j]) begin
                    r_qm[j]  <= ge ? diff[DW:0] : t[DW:0];
                    r_qr[j]  <= {root_in[DW-2:0], ge};
                    r_qx[j]  <= {rad_in[SW-3:0], 2'b00};
                    r_qmx[j] <= mx_in;
                    r_qmy[j] <= my_in;
                    r_qmz[j] <= mz_in;
                    r_qsg[j] <= sg_in;
                    r_qsr[j] <= sr_in;
                end
            end
        end
    endgenerate

    // ---------------- compare stage ----------------
    logic [DW-1:0] sq_root;
    logic [DW-1:0] sr_ext;
    logic [DW-1:0] dep_full;
    logic [NW-1:0] half_root;
    logic          r_chit;
    logic          r_ccoi;
    logic [W-1:0]  r_cdep;
    logic [2:0]    r_csg;
    logic [NW-1:0] r_num [3];
    logic [DW-1:0] r_den;

    assign sq_root   = r_qr[DW-1];
    assign sr_ext    = {2'b00, r_qsr[DW-1]};
    assign dep_full  = sr_ext - sq_root;
    assign half_root = {{(F+1){1'b0}}, sq_root[DW-1:1]};

    always_ff @(posedge i_clk) begin
        if (rdy[CS]) begin
            r_chit   <= (sq_root <= sr_ext);
            r_ccoi   <= (sq_root == '0);
            r_cdep   <= dep_full[W-1:0];
            r_csg    <= r_qsg[DW-1];
            r_den    <= sq_root;
            r_num[0] <= {1'b0, r_qmx[DW-1], {F{1'b0}}} + half_root;
            r_num[1] <= {1'b0, r_qmy[DW-1], {F{1'b0}}} + half_root;
            r_num[2] <= {1'b0, r_qmz[DW-1], {F{1'b0}}} + half_root;
        end
    end

    // ---------------- dividers ----------------
    logic [NQ-1:0] quo [3];

    generate
        for (c = 0; c < 3; c++) begin : g_div
            ssc_div_lane #(
                .DW(DW),
                .NW(NW),
                .NQ(NQ)
            ) u_lane (
                .i_clk (i_clk),
                .i_en  (rdy[D0 +: NQ]),
                .i_num (r_num[c]),
                .i_den (r_den),
                .o_quo (quo[c])
            );
        end
    endgenerate

    logic          r_dhit [NQ];
    logic          r_dcoi [NQ];
    logic [W-1:0]  r_ddep [NQ];
    logic [2:0]    r_dsg  [NQ];

    generate
        for (j = 0; j < NQ; j++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (rdy[D0+j]) begin
                    if (j == 0) begin
                        r_dhit[j] <= r_chit;
                        r_dcoi[j] <= r_ccoi;
                        r_ddep[j] <= r_cdep;
                        r_dsg[j]  <= r_csg;
                    end else begin
                        r_dhit[j] <= r_dhit[(j == 0) ? 0 : j-1];
                        r_dcoi[j] <= r_dcoi[(j == 0) ? 0 : j-1];
                        r_ddep[j] <= r_ddep[(j == 0) ? 0 : j-1];
                        r_dsg[j]  <= r_dsg[(j == 0) ? 0 : j-1];
                    end
                end
            end
        end
    endgenerate

    // ---------------- output stage ----------------
    logic          hit_l;
    logic          use_n;
    logic [OW-1:0] nrm [3];
    logic [OW-1:0] r_onx;
    logic [OW-1:0] r_ony;
    logic [OW-1:0] r_onz;
    logic          r_ohit;
    logic          r_ocoi;
    logic [W-1:0]  r_odep;

    assign hit_l = r_dhit[NQ-1];
    assign use_n = hit_l && !r_dcoi[NQ-1];

    generate
        for (c = 0; c < 3; c++) begin : g_norm
            logic [NQ+OW-1:0] qx;
            logic [OW-1:0]    q16;
            assign qx     = {{OW{1'b0}}, quo[c]};
            assign q16    = qx[OW-1:0];
            assign nrm[c] = !use_n ? '0 : (r_dsg[NQ-1][c] ? (~q16 + 1'b1) : q16);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (rdy[OS]) begin
            r_ohit <= hit_l;
            r_ocoi <= hit_l && r_dcoi[NQ-1];
            r_odep <= hit_l ? r_ddep[NQ-1] : '0;
            r_onx  <= nrm[0];
            r_ony  <= nrm[1];
            r_onz  <= nrm[2];
        end
    end

    assign o_hit        = r_ohit;
    assign o_coincident = r_ocoi;
    assign o_depth      = r_odep;
    assign o_normal_x   = r_onx;
    assign o_normal_y   = r_ony;
    assign o_normal_z   = r_onz;

endmodule

`default_nettype wire

/* hdl/ssc_div_lane.sv */
// ----------------------------------------------------------------------------
// ssc_div_lane
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_div_lane #(
    parameter int DW = 26,
    parameter int NW = 40,
    parameter int NQ = 15
) (
    input  wire logic          i_clk,
    input  wire logic [NQ-1:0] i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [NQ-1:0] o_quo
);

    logic [DW-1:0] r_rem [NQ];
    logic [NW-1:0] r_num [NQ];
    logic [DW-1:0] r_den [NQ];
    logic [NQ-1:0] r_q   [NQ];

    genvar j;
    generate
        for (j = 0; j < NQ; j++) begin : g_stage
            logic [DW-1:0] rem_in;
            logic [NW-1:0] num_in;
            logic [DW-1:0] den_in;
            logic [NQ-1:0] q_in;
            logic [DW:0]   t;
            logic [DW:0]   diff;
            logic          ge;
            logic [DW-1:0] n_rem;
            logic [NQ-1:0] n_q;

            if (j == 0) begin : g_first
                assign rem_in = {1'b0, i_num[NW-1:NQ]};
                assign num_in = i_num;
                assign den_in = i_den;
                assign q_in   = '0;
            end else begin : g_next
                assign rem_in = r_rem[j-1];
                assign num_in = r_num[j-1];
                assign den_in = r_den[j-1];
                assign q_in   = r_q[j-1];
            end

            always_comb begin
                t     = {rem_in, num_in[NQ-1-j]};
                diff  = t - {1'b0, den_in};
                ge    = (t >= {1'b0, den_in});
                n_rem = ge ? diff[DW-1:0] : t[DW-1:0];
                n_q   = {q_in[NQ-2:0], ge};
            end

            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j] <= n_rem;
                    r_num[j] <= num_in;
                    r_den[j] <= den_in;
                    r_q[j]   <= n_q;
                end
            end
        end
    endgenerate

    assign o_quo = r_q[NQ-1];

endmodule

`default_nettype wire

/* dv/sphere_sphere_contact_top_test.sv */
// ----------------------------------------------------------------------------
// sphere_sphere_contact_top_test
// Drives sphere pair words through the contact pipeline with random idling
// on both channels and compares each result word against an expected word from
// a predictor or from a table of directed cases.
`default_nettype none

module sphere_sphere_contact_top_test;
    import ssc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = SSC_COORD_BITS;
    localparam int NF = SSC_NORMAL_FRAC_BITS;
    localparam int NW = SSC_NORMAL_WIDTH;
    localparam int LATENCY = CB + NF + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM = 1000;

    typedef struct packed {
        logic [CB-1:0] ax, ay, az;
        logic [CB-2:0] ra;
        logic [CB-1:0] bx, by, bz;
        logic [CB-2:0] rb;
    } pair_t;

    typedef struct packed {
        logic          hit;
        logic [NW-1:0] nx, ny, nz;
        logic [CB-1:0] depth;
        logic          coincident;
    } contact_t;

    typedef struct {
        pair_t    p;
        logic     known;
        contact_t r;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid, o_hit, o_coincident;
    logic signed [NW-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic [CB-1:0] o_depth;
    pair_t pair_q = '0;

    contact_t expected_contacts[$];
    int errors = 0;
    int cycles = 0;
    logic stim_done = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    sphere_sphere_contact_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_center_a_x(pair_q.ax), .i_center_a_y(pair_q.ay),
        .i_center_a_z(pair_q.az), .i_radius_a(pair_q.ra),
        .i_center_b_x(pair_q.bx), .i_center_b_y(pair_q.by),
        .i_center_b_z(pair_q.bz), .i_radius_b(pair_q.rb),
        .o_valid(o_valid), .i_ready(i_ready), .o_hit(o_hit),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_depth(o_depth), .o_coincident(o_coincident)
    );

    function automatic logic [NW-1:0] normal_comp(longint d, longint unsigned len);
        longint unsigned m, q;
        m = (d < 0) ? -d : d;
        q = ((m << NF) + (len >> 1)) / len;
        if (d < 0) q = -q;
        return q[NW-1:0];
    endfunction

    function automatic contact_t predict_contact(pair_t p);
        longint dx, dy, dz;
        logic [69:0] sq, c;
        longint unsigned len, rsum;
        contact_t r;
        dx = longint'($signed(p.bx)) - longint'($signed(p.ax));
        dy = longint'($signed(p.by)) - longint'($signed(p.ay));
        dz = longint'($signed(p.bz)) - longint'($signed(p.az));
        sq = 70'(dx * dx) + 70'(dy * dy) + 70'(dz * dz);
        len = 0;
        for (int b = 33; b >= 0; b--) begin
            c = 70'(len | (64'd1 << b));
            if (c * c <= sq) len = c[63:0];
        end
        rsum = longint'(p.ra) + longint'(p.rb);
        r = '0;
        if (len <= rsum) begin
            r.hit = 1'b1;
            r.depth = CB'(rsum - len);
            if (len == 0) begin
                r.coincident = 1'b1;
            end else begin
                r.nx = normal_comp(dx, len);
                r.ny = normal_comp(dy, len);
                r.nz = normal_comp(dz, len);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic pair_t random_pair();
        pair_t p;
        int span;
        p = pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 3) != 0) begin
            span = 1 << $urandom_range(2, 22);
            p.bx = p.ax + CB'($urandom_range(0, 2 * span) - span);
            p.by = p.ay + CB'($urandom_range(0, 2 * span) - span);
            p.bz = p.az + CB'($urandom_range(0, 2 * span) - span);
            p.ra = (CB-1)'($urandom_range(0, span));
            p.rb = (CB-1)'($urandom_range(0, span));
        end
        if ($urandom_range(0, 30) == 0) begin
            p.bx = p.ax; p.by = p.ay; p.bz = p.az;
        end
        return p;
    endfunction

    row_t dir_rows[$];

    task automatic add_row(pair_t p, logic known, contact_t r);
        row_t t;
        t.p = p; t.known = known; t.r = r;
        dir_rows.push_back(t);
    endtask

    localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CB-2:0] RMAX = '1;

    task automatic send_pair(pair_t p, row_t row, logic use_row);
        int idle;
        idle = $urandom_range(0, 13);
        if (idle > 0) begin
            i_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        pair_q <= p;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_contacts.push_back(use_row && row.known ? row.r : predict_contact(p));
    endtask

    initial begin
        row_t none;
        none.known = 1'b0;
        add_row('0, 1'b1, contact_t'({1'b1, 48'd0, 24'd0, 1'b1}));
        add_row('{ax:CMAX, ay:CMAX, az:CMAX, ra:RMAX, bx:CMAX, by:CMAX, bz:CMAX, rb:RMAX},
            1'b1, contact_t'({1'b1, 48'd0, 24'hFFFFFE, 1'b1}));
        add_row('{ax:CMIN, ay:CMIN, az:CMIN, ra:0, bx:CMAX, by:CMAX, bz:CMAX, rb:0},
            1'b1, '0);
        add_row('{ax:0, ay:0, az:0, ra:256, bx:256, by:0, bz:0, rb:0},
            1'b1, contact_t'({1'b1, 16'h4000, 16'd0, 16'd0, 24'd0, 1'b0}));
        add_row('{ax:0, ay:0, az:0, ra:0, bx:0, by:-512, bz:0, rb:512},
            1'b1, contact_t'({1'b1, 16'd0, 16'hC000, 16'd0, 24'd0, 1'b0}));
        add_row('{ax:0, ay:0, az:0, ra:100, bx:0, by:0, bz:300, rb:100}, 1'b1, '0);
        add_row('{ax:CMIN, ay:CMIN, az:CMIN, ra:RMAX, bx:CMAX, by:CMAX, bz:CMAX, rb:RMAX},
            1'b0, '0);
        add_row('{ax:CMAX, ay:CMIN, az:0, ra:RMAX, bx:CMIN, by:CMAX, bz:1, rb:RMAX},
            1'b0, '0);
        add_row('{ax:10, ay:-20, az:30, ra:50, bx:-40, by:25, bz:-5, rb:60}, 1'b0, '0);
        add_row('{ax:0, ay:0, az:0, ra:1, bx:1, by:1, bz:1, rb:1}, 1'b0, '0);
        add_row('{ax:5, ay:5, az:5, ra:0, bx:6, by:5, bz:5, rb:0}, 1'b0, '0);
        add_row('{ax:-7, ay:3, az:9, ra:8, bx:-7, by:3, bz:9, rb:0}, 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[k]) send_pair(dir_rows[k].p, dir_rows[k], 1'b1);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                wait (expected_contacts.size() == 0);
                @(posedge i_clk);
            end
            send_pair(random_pair(), none, 1'b0);
        end
        i_valid <= 1'b0;
        stim_done <= 1'b1;
    end

    always @(posedge i_clk) begin
        contact_t e;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_contacts.size() == 0) begin
                    report_mismatch("unexpected word", 0, 0);
                end else begin
                    e = expected_contacts.pop_front();
                    if (o_hit !== e.hit) report_mismatch("hit", o_hit, e.hit);
                    if (o_normal_x !== e.nx) report_mismatch("normal_x", o_normal_x, e.nx);
                    if (o_normal_y !== e.ny) report_mismatch("normal_y", o_normal_y, e.ny);
                    if (o_normal_z !== e.nz) report_mismatch("normal_z", o_normal_z, e.nz);
                    if (o_depth !== e.depth) report_mismatch("depth", o_depth, e.depth);
                    if (o_coincident !== e.coincident)
                        report_mismatch("coincident", o_coincident, e.coincident);
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (!i_ready || o_valid) begin
            if ($urandom_range(0, 2) == 0) begin
                stall_left <= $urandom_range(0, 13);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        wait (stim_done && expected_contacts.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0 && expected_contacts.size() == 0) begin
            $display("sphere_sphere_contact_top_test: clean");
        end else begin
            $display("sphere_sphere_contact_top_test: errors");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("sphere_sphere_contact_top_test: errors");
            $finish;
        end
    end

endmodule

`default_nettype wire
